// ----- hdl/rdat_pkg.sv -----
// ---------------------------------------------------------------------------
// rdat_pkg: shared types and constants for the datagram ack tracker
// widths, action and result codes, register indexes, sequencer states
// ---------------------------------------------------------------------------
`default_nettype none
package rdat_pkg;
   localparam int WindowDepth  = 16;
   localparam int PendingDepth = 32;
   localparam int MaskBits     = 16;
   localparam int WinIdxW      = $clog2(WindowDepth);
   localparam int WinCntW      = $clog2(WindowDepth + 1);
   localparam int PendIdxW     = $clog2(PendingDepth);
   localparam int PendCntW     = $clog2(PendingDepth + 1);
   localparam int MaskIdxW     = $clog2(MaskBits);

   typedef enum logic [1:0] {
      ACT_RECV = 2'd0,
      ACT_SEND = 2'd1,
      ACT_TICK = 2'd2,
      ACT_NONE = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      KIND_RECV   = 2'd0,
      KIND_ASSIGN = 2'd1,
      KIND_RESEND = 2'd2,
      KIND_TICK   = 2'd3
   } kind_type;

   localparam logic REG_RESEND   = 1'b0;
   localparam logic REG_RESPONSE = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PEND,      // walk pending table (receive compaction, tick scan)
      ST_PUSH,      // window repeat check done, update window
      ST_MAX,       // compute window max
      ST_MASK,      // build ack bits, one window search per bit
      ST_EMIT,      // emit single result
      ST_TICKEND
   } seq_state_type;

   typedef struct packed {
      logic [1:0]  action;
      logic [31:0] now;
      logic [15:0] packet_id;
      logic [15:0] peer_ack;
      logic [15:0] peer_ack_bits;
   } item_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] out_id;
      logic        is_repeat;
      logic [15:0] own_ack;
      logic [15:0] own_ack_bits;
      logic [5:0]  acked_count;
      logic        timed_out;
      logic        table_full;
      logic        last;
   } result_type;

   // peer acks an id directly or through one of the offset bits
   function automatic logic peer_acks(input logic [15:0] id, input logic [15:0] ack,
                                      input logic [15:0] bits);
      logic hit;
      hit = (id == ack);
      for (int j = 0; j < 16; j++) begin
         if (bits[j] && id == 16'(ack - 16'(j + 1))) hit = 1'b1;
      end
      return hit;
   endfunction
endpackage
`default_nettype wire

// ----- hdl/rdat_if.sv -----
// ---------------------------------------------------------------------------
// rdat_if: valid/ready channel interfaces
// item, result and register write channels
// ---------------------------------------------------------------------------
`default_nettype none
interface rdat_req_if;
   import rdat_pkg::*;
   logic       valid;
   logic       ready;
   item_type   data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface rdat_rsp_if;
   import rdat_pkg::*;
   logic       valid;
   logic       ready;
   result_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface rdat_csr_if;
   logic        valid;
   logic        ready;
   logic        index;
   logic [31:0] wdata;
   modport source (output valid, output index, output wdata, input ready);
   modport sink   (input valid, input index, input wdata, output ready);
endinterface
`default_nettype wire

// ----- hdl/rdat_front.sv -----
// ---------------------------------------------------------------------------
// rdat_front: input stage and two-entry item queue
// accepts items, drops unknown actions, buffers toward the sequencer
// ---------------------------------------------------------------------------
`default_nettype none
module rdat_front
   import rdat_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   rdat_req_if.sink  req,
   output item_type  q_data,
   output logic      q_valid,
   input  wire logic q_pop
);
   item_type   mem_ff [2];
   logic       wr_ff, wr_in, rd_ff, rd_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       push;

   assign req.ready = (cnt_ff != 2'd2);
   // unknown action yields nothing, so it never enters the queue
   assign push      = req.valid && req.ready && (req.data.action != ACT_NONE);
   assign q_valid   = (cnt_ff != 2'd0);
   assign q_data    = mem_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff ^ push;
      rd_in  = rd_ff ^ q_pop;
      cnt_in = 2'(cnt_ff + {1'b0, push} - {1'b0, q_pop});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 1'b0;
         rd_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) mem_ff[wr_ff] <= req.data;
   end

`ifndef SYNTHESIS
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid) else $error("pop from empty queue");
   a_cnt_step: assert property (@(posedge clock) disable iff (reset)
      (push && !q_pop) |=> cnt_ff == $past(cnt_ff) + 2'd1) else $error("count slip");
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      cnt_ff == 2'd2 |-> !req.ready) else $error("accept while full");
`endif
endmodule
`default_nettype wire

// ----- hdl/rdat_back.sv -----
// ---------------------------------------------------------------------------
// rdat_back: sequencer holding window, pending table and timers
// walks the tables one entry per cycle unless a held result stalls it,
// emits results through a register
`default_nettype none
module rdat_back
   import rdat_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire item_type    q_data,
   input  wire logic        q_valid,
   output logic             q_pop,
   input  wire logic [31:0] resend_timeout,
   input  wire logic [31:0] response_timeout,
   rdat_rsp_if.source       rsp
);
   // tables: registers read at one running index each
   logic [15:0] win_ff [WindowDepth];
   logic [15:0] pid_ff [PendingDepth];
   logic [31:0] ptm_ff [PendingDepth];

   seq_state_type st_ff, st_in;
   logic [WinCntW-1:0]  wcnt_ff;
   logic [PendCntW-1:0] pcnt_ff;
   logic [15:0]         next_ff;
   logic [31:0]         heard_ff;

   logic [PendCntW-1:0] ri_ff;   // read index
   logic [PendCntW-1:0] wi_ff;   // compaction write index
   logic [WinCntW-1:0]  wj_ff;   // window index
   logic [MaskIdxW:0]   mi_ff;   // mask bit index
   logic                rep_ff;
   logic [15:0]         ack_ff, bits_ff;
   logic [5:0]          rem_ff;

   result_type out_ff;
   logic       ov_ff;
   logic       out_free;
   item_type   it;

   assign it        = q_data;
   assign rsp.valid = ov_ff;
   assign rsp.data  = out_ff;
   assign out_free  = !ov_ff || rsp.ready;

   // per-cycle views of the current entries
   logic [PendIdxW-1:0] ri;
   logic [15:0]         cur_id;
   logic [31:0]         cur_tm;
   logic                overdue;
   logic [15:0]         target;
   logic                win_hit;
   logic [WinIdxW-1:0]  wj;
   assign ri      = ri_ff[PendIdxW-1:0];
   assign cur_id  = pid_ff[ri];
   assign cur_tm  = ptm_ff[ri];
   assign overdue = {1'b0, it.now} > ({1'b0, cur_tm} + {1'b0, resend_timeout});
   assign wj      = wj_ff[WinIdxW-1:0];
   // one compare per cycle: during ST_PUSH against packet id, in ST_MASK against ack-i-1
   assign target  = (st_ff == ST_MASK) ? 16'(ack_ff - 16'(mi_ff) - 16'd1) : it.packet_id;
   assign win_hit = (wj_ff < wcnt_ff) && (win_ff[wj] == target);

   logic pend_done, win_done, mask_done;
   assign pend_done = (ri_ff >= pcnt_ff);
   assign win_done  = (wj_ff >= wcnt_ff) || win_hit;
   assign mask_done = (mi_ff == (MaskIdxW+1)'(MaskBits));

   // result register loads on every item end and on each resend
   logic ov_in;
   assign ov_in = q_pop ||
                  (st_ff == ST_PEND && it.action == ACT_TICK && !pend_done &&
                   overdue && out_free) ||
                  (ov_ff && !rsp.ready);

   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         ST_IDLE:    if (q_valid && out_free) begin
            if (it.action == ACT_SEND) st_in = ST_EMIT;
            else st_in = ST_PEND;
         end
         ST_PEND:    if (pend_done) begin
            if (it.action == ACT_TICK) st_in = ST_TICKEND;
            else st_in = ST_PUSH;
         end
         ST_PUSH:    if (win_done || it.packet_id == 16'd0) st_in = ST_MAX;
         ST_MAX:     if (wj_ff >= wcnt_ff) st_in = ST_MASK;
         ST_MASK:    if (mask_done && out_free) st_in = ST_IDLE;
         ST_EMIT:    st_in = ST_IDLE;
         ST_TICKEND: if (out_free) st_in = ST_IDLE;
         default:    st_in = ST_IDLE;
      endcase
   end

   always_comb begin
      q_pop = 1'b0;
      unique case (st_ff)
         ST_MASK:    q_pop = mask_done && out_free;
         ST_EMIT:    q_pop = 1'b1;
         ST_TICKEND: q_pop = out_free;
         default:    q_pop = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff    <= ST_IDLE;
         wcnt_ff  <= '0;
         pcnt_ff  <= '0;
         next_ff  <= '0;
         heard_ff <= '0;
         ov_ff    <= 1'b0;
      end else begin
         st_ff <= st_in;
         ov_ff <= ov_in;
         unique case (st_ff)
            ST_IDLE: begin
               ri_ff <= '0; wi_ff <= '0; wj_ff <= '0; mi_ff <= '0;
               rem_ff <= '0; rep_ff <= 1'b0; ack_ff <= '0; bits_ff <= '0;
            end
            ST_PEND: begin
               if (!pend_done) begin
                  if (it.action == ACT_TICK) begin
                     if (overdue) begin
                        if (out_free) begin
                           ptm_ff[ri] <= it.now;
                           out_ff <= '{kind: KIND_RESEND, out_id: cur_id, default: '0};
                           ri_ff  <= ri_ff + 1'b1;
                        end
                     end else ri_ff <= ri_ff + 1'b1;
                  end else begin
                     if (peer_acks(cur_id, it.peer_ack, it.peer_ack_bits))
                        rem_ff <= rem_ff + 6'd1;
                     else begin
                        pid_ff[wi_ff[PendIdxW-1:0]] <= cur_id;
                        ptm_ff[wi_ff[PendIdxW-1:0]] <= cur_tm;
                        wi_ff <= wi_ff + 1'b1;
                     end
                     ri_ff <= ri_ff + 1'b1;
                  end
               end else if (it.action == ACT_RECV) pcnt_ff <= wi_ff;
            end
            ST_PUSH: begin
               if (it.packet_id != 16'd0 && !win_done) wj_ff <= wj_ff + 1'b1;
               else begin
                  if (!(win_hit && it.packet_id != 16'd0)) begin
                     if (wcnt_ff == WinCntW'(WindowDepth)) begin
                        for (int k = 0; k < WindowDepth - 1; k++) win_ff[k] <= win_ff[k+1];
                        win_ff[WindowDepth-1] <= it.packet_id;
                     end else begin
                        win_ff[wcnt_ff[WinIdxW-1:0]] <= it.packet_id;
                        wcnt_ff <= wcnt_ff + 1'b1;
                     end
                  end
                  rep_ff   <= win_hit && it.packet_id != 16'd0;
                  heard_ff <= it.now;
                  wj_ff    <= '0;
               end
            end
            ST_MAX: begin
               if (wj_ff < wcnt_ff) begin
                  if (win_ff[wj] > ack_ff) ack_ff <= win_ff[wj];
                  wj_ff <= wj_ff + 1'b1;
               end else wj_ff <= '0;
            end
            ST_MASK: begin
               if (!mask_done) begin
                  if (win_done) begin
                     if (win_hit && ack_ff >= 16'(mi_ff) + 16'd1)
                        bits_ff[mi_ff[MaskIdxW-1:0]] <= 1'b1;
                     mi_ff <= mi_ff + 1'b1;
                     wj_ff <= '0;
                  end else wj_ff <= wj_ff + 1'b1;
               end else if (out_free) begin
                  out_ff <= '{kind: KIND_RECV, is_repeat: rep_ff, own_ack: ack_ff,
                              own_ack_bits: bits_ff, acked_count: rem_ff,
                              last: 1'b1, default: '0};
               end
            end
            ST_EMIT: begin
               if (pcnt_ff == PendCntW'(PendingDepth))
                  out_ff <= '{kind: KIND_ASSIGN, table_full: 1'b1, last: 1'b1, default: '0};
               else begin
                  pid_ff[pcnt_ff[PendIdxW-1:0]] <= 16'(next_ff + 16'd1);
                  ptm_ff[pcnt_ff[PendIdxW-1:0]] <= it.now;
                  pcnt_ff <= pcnt_ff + 1'b1;
                  next_ff <= 16'(next_ff + 16'd1);
                  out_ff  <= '{kind: KIND_ASSIGN, out_id: 16'(next_ff + 16'd1),
                               last: 1'b1, default: '0};
               end
            end
            ST_TICKEND: if (out_free) begin
               out_ff <= '{kind: KIND_TICK, last: 1'b1,
                           timed_out: {1'b0, it.now} >
                                      ({1'b0, heard_ff} + {1'b0, response_timeout}),
                           default: '0};
            end
            default: ;
         endcase
      end
   end

`ifndef SYNTHESIS
   a_pcnt_bound: assert property (@(posedge clock) disable iff (reset)
      pcnt_ff <= PendCntW'(PendingDepth)) else $error("pending overflow");
   a_wcnt_bound: assert property (@(posedge clock) disable iff (reset)
      wcnt_ff <= WinCntW'(WindowDepth)) else $error("window overflow");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (ov_ff && !rsp.ready) |=> $stable(out_ff)) else $error("result changed while held");
   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> st_ff == ST_IDLE) else $error("pop outside item end");
`endif
endmodule
`default_nettype wire

// ----- hdl/reliable_datagram_ack_tracker_unit.sv -----
// ---------------------------------------------------------------------------
// reliable_datagram_ack_tracker_unit: ack tracking for one peer
// receive window, pending send table, resend and response timers
// ---------------------------------------------------------------------------
//  channel  | dir | content
//  req_     | in  | action, now, packet_id, peer_ack, peer_ack_bits
//  rsp_     | out | kind, out_id, is_repeat, own_ack, own_ack_bits, ..., last
//  csr_     | in  | index 0 resend_timeout, 1 response_timeout
//
//  send: IDLE, EMIT. tick: IDLE, pending walk, TICKEND, plus output stalls
//  receive: IDLE, pending walk, window repeat check, window max, per-bit window compare
//  (window compare sequencer dominates)
//  synchronous reset clears counts, next id, last heard, timeouts to 200 / 2000
//  a two-entry queue lets items arrive while the sequencer works
`default_nettype none
module reliable_datagram_ack_tracker_unit
   import rdat_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   rdat_req_if.sink  req,
   rdat_rsp_if.source rsp,
   rdat_csr_if.sink  csr
);
   item_type    q_data;
   logic        q_valid, q_pop;
   logic [31:0] resend_ff, response_ff;

   // registers always writable
   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         resend_ff   <= 32'd200;
         response_ff <= 32'd2000;
      end else if (csr.valid) begin
         if (csr.index == REG_RESEND) resend_ff <= csr.wdata;
         else response_ff <= csr.wdata;
      end
   end

   rdat_front u_front (
      .clock  (clock),
      .reset  (reset),
      .req    (req),
      .q_data (q_data),
      .q_valid(q_valid),
      .q_pop  (q_pop)
   );

   rdat_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_data          (q_data),
      .q_valid         (q_valid),
      .q_pop           (q_pop),
      .resend_timeout  (resend_ff),
      .response_timeout(response_ff),
      .rsp             (rsp)
   );

`ifndef SYNTHESIS
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && !rsp.ready) |=> rsp.valid) else $error("result dropped");
   a_csr_reg: assert property (@(posedge clock) disable iff (reset)
      (csr.valid && csr.index == REG_RESEND) |=> resend_ff == $past(csr.wdata))
      else $error("register write lost");
   a_last_kind: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.data.kind == KIND_RESEND) |-> !rsp.data.last)
      else $error("resend marked last");
`endif
endmodule
`default_nettype wire
